[sv/nms_pkg.sv]
// ---------------------------------------------------------------------------
// nms_pkg: shared types, constants and a function for non-maximum suppression
// Holds the sizes, the controller state type, the command and status bundles
// and the box extent function used by the datapath.
// ---------------------------------------------------------------------------
package nms_pkg;

	localparam int MAX_BOXES = 64;
	localparam int IDX_W     = $clog2(MAX_BOXES);
	localparam int CNT_W     = IDX_W + 1;
	localparam int COORD_W   = 16;
	localparam int SCORE_W   = 16;
	localparam int THR_W     = 16;
	localparam int MAXSEL_W  = 7;
	localparam int BATCH_W   = 8;
	localparam int CLASS_W   = 10;
	localparam int EXT_W     = COORD_W + 2;
	localparam int DIF_W     = EXT_W + 1;
	localparam int AREA_W    = 2 * DIF_W;
	localparam int SUM_W     = AREA_W + 1;
	localparam int PROD_W    = SUM_W + THR_W;
	localparam int BOX_W     = 4 * COORD_W;
	localparam int EXTS_W    = 4 * EXT_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 24;
	localparam int OUT_USER_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_FORMAT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_USE_SCORE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEL    = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_EXT,
		S_CHECK,
		S_DECIDE,
		S_ORD,
		S_OLD,
		S_OWAIT
	} state_t;

	typedef struct packed {
		logic ld;
		logic scan_clr;
		logic scan_issue;
		logic pick;
		logic ext_ld;
		logic chk_clr;
		logic chk_issue;
		logic keep;
		logic out_ld;
		logic out_next;
		logic set_clr;
	} cmd_t;

	typedef struct packed {
		logic scan_rem;
		logic scan_pend;
		logic found;
		logic chk_rem;
		logic pipe_busy;
		logic supp;
		logic lim_next;
		logic out_taken;
		logic out_last;
	} sts_t;

	// Extents at twice the coordinate scale: {y hi, y lo, x hi, x lo}.
	function automatic logic [EXTS_W-1:0] box_ext(input logic [BOX_W-1:0] box,
		input logic fmt);
		logic signed [EXT_W-1:0] a, b, c, d, e0, e1, e2, e3;
		a = EXT_W'($signed(box[0*COORD_W +: COORD_W]));
		b = EXT_W'($signed(box[1*COORD_W +: COORD_W]));
		c = EXT_W'($signed(box[2*COORD_W +: COORD_W]));
		d = EXT_W'($signed(box[3*COORD_W +: COORD_W]));
		if (fmt) begin
			e0 = (a <<< 1) - c;
			e1 = (a <<< 1) + c;
			e2 = (b <<< 1) - d;
			e3 = (b <<< 1) + d;
		end else begin
			e0 = ((b < d) ? b : d) <<< 1;
			e1 = ((b < d) ? d : b) <<< 1;
			e2 = ((a < c) ? a : c) <<< 1;
			e3 = ((a < c) ? c : a) <<< 1;
		end
		return {e3, e2, e1, e0};
	endfunction

endpackage

[sv/non_max_suppression_top.sv]
// ---------------------------------------------------------------------------
// non_max_suppression_top: non-maximum suppression over one set of boxes
// Loads a set of scored boxes, then keeps boxes by descending score unless
// an already kept box overlaps them beyond the IoU threshold.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Carries
// s_axis    in         one box request: score, four coordinates, batch, class
// m_axis    out        one result request: batch, class, index, flags
// cfg       in         register writes, no read-back
//
// A box request is taken whenever the block is idle. The request that closes a
// set starts selection, during which no further box is taken. Each candidate
// costs one scan over the stored scores and one pass over the kept boxes
// through a five-stage overlap pipeline. Each result is then read from the
// kept list, loaded into the output register and held until m_axis_tready
// takes it. Reset is asynchronous and clears the control state; stored boxes
// are not cleared and need none. A stalled result holds on m_axis until it is
// taken.
// ---------------------------------------------------------------------------
module non_max_suppression_top import nms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// Box requests.
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// Fields from bit 0: score, coord_a, coord_b, coord_c, coord_d, batch_id,
	// class_id, then zero padding.
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// last_box: closes the set and starts selection.
	input  logic                  s_axis_tlast,
	// Result requests.
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// Fields from bit 0: out_batch, out_class, load position of the kept box.
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// Fields from bit 0: valid_res, overflow.
	output logic [OUT_USER_W-1:0] m_axis_tuser,
	// last_result: final result of the set.
	output logic                  m_axis_tlast,
	// Configuration writes.
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// The controller decides when a box request is taken and walks the
	// datapath through scan, overlap checks and result delivery.
	nms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds every store and the arithmetic of the overlap test.
	nms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

[sv/nms_ctrl.sv]
// ---------------------------------------------------------------------------
// nms_ctrl: sequencing state machine
// Steps the datapath through loading, the score scan, the overlap checks
// and the delivery of results.
// ---------------------------------------------------------------------------
module nms_ctrl import nms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ld = 1'b1;
					if (in_last) begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				if (sts.scan_rem) begin
					cmd.scan_issue = 1'b1;
				end else if (!sts.scan_pend) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				if (sts.found) begin
					cmd.pick = 1'b1;
					state_d  = S_EXT;
				end else begin
					state_d = S_ORD;
				end
			end
			S_EXT: begin
				cmd.ext_ld  = 1'b1;
				cmd.chk_clr = 1'b1;
				state_d     = S_CHECK;
			end
			S_CHECK: begin
				if (sts.chk_rem) begin
					cmd.chk_issue = 1'b1;
				end else if (!sts.pipe_busy) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.supp) begin
					cmd.keep = 1'b1;
				end
				if (!sts.supp && sts.lim_next) begin
					state_d = S_ORD;
				end else begin
					cmd.scan_clr = 1'b1;
					state_d      = S_SCAN;
				end
			end
			S_ORD: begin
				state_d = S_OLD;
			end
			S_OLD: begin
				cmd.out_ld = 1'b1;
				state_d    = S_OWAIT;
			end
			S_OWAIT: begin
				if (sts.out_taken) begin
					if (sts.out_last) begin
						cmd.set_clr = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = S_ORD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/nms_dp.sv]
// ---------------------------------------------------------------------------
// nms_dp: storage, score scan and overlap pipeline
// Holds the box and score memories, the kept lists, the configuration
// registers, the best-score search and the five-stage overlap test.
// ---------------------------------------------------------------------------
module nms_dp import nms_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	input  logic [IN_DATA_W-1:0]  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [OUT_USER_W-1:0] out_user,
	output logic                  out_last
);

	// Configuration registers.
	logic                      fmt_q;
	logic [THR_W-1:0]          iou_thr_q;
	logic signed [SCORE_W-1:0] score_thr_q;
	logic                      use_thr_q;
	logic [MAXSEL_W-1:0]       max_sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= 1'b0;
			iou_thr_q   <= '0;
			score_thr_q <= '0;
			use_thr_q   <= 1'b0;
			max_sel_q   <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_BOX_FORMAT: fmt_q       <= cfg_data[0];
				CFG_IOU_THR:    iou_thr_q   <= cfg_data[THR_W-1:0];
				CFG_SCORE_THR:  score_thr_q <= $signed(cfg_data[SCORE_W-1:0]);
				CFG_USE_SCORE:  use_thr_q   <= cfg_data[0];
				CFG_MAX_SEL:    max_sel_q   <= cfg_data[MAXSEL_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpacked request fields.
	logic [SCORE_W-1:0] in_score;
	logic [BOX_W-1:0]   in_box;
	logic [BATCH_W-1:0] in_batch;
	logic [CLASS_W-1:0] in_class;

	assign in_score = in_data[SCORE_W-1:0];
	assign in_box   = in_data[SCORE_W +: BOX_W];
	assign in_batch = in_data[SCORE_W+BOX_W +: BATCH_W];
	assign in_class = in_data[SCORE_W+BOX_W+BATCH_W +: CLASS_W];

	// Set counters and flags.
	logic [CNT_W-1:0]     load_cnt_q, kept_cnt_q, scan_cnt_q, chk_cnt_q, out_cnt_q;
	logic                 ovf_q;
	logic [MAX_BOXES-1:0] visited_q;
	logic [BATCH_W-1:0]   batch_q;
	logic [CLASS_W-1:0]   class_q;

	// Memories.
	logic [BOX_W-1:0]   box_mem   [MAX_BOXES];
	logic [SCORE_W-1:0] score_mem [MAX_BOXES];
	logic [EXTS_W-1:0]  kext_mem  [MAX_BOXES];
	logic [IDX_W-1:0]   kidx_mem  [MAX_BOXES];

	logic               room;
	assign room = (load_cnt_q < CNT_W'(MAX_BOXES));

	always_ff @(posedge clk) begin
		if (cmd.ld && room) begin
			box_mem[load_cnt_q[IDX_W-1:0]]   <= in_box;
			score_mem[load_cnt_q[IDX_W-1:0]] <= in_score;
		end
		if (cmd.ld) begin
			batch_q <= in_batch;
			class_q <= in_class;
		end
	end

	// Score scan: one stored score per cycle, registered read.
	logic [SCORE_W-1:0]        sd_s1;
	logic [IDX_W-1:0]          sidx_s1;
	logic                      sv_s1;
	logic                      best_found_q;
	logic [IDX_W-1:0]          best_idx_q;
	logic signed [SCORE_W-1:0] best_score_q;
	logic                      elig, take;

	always_ff @(posedge clk) begin
		sd_s1   <= score_mem[scan_cnt_q[IDX_W-1:0]];
		sidx_s1 <= scan_cnt_q[IDX_W-1:0];
	end

	assign elig = !visited_q[sidx_s1] &&
		(!use_thr_q || ($signed(sd_s1) > score_thr_q));
	// Ascending scan with a strict compare keeps the lower index on a tie.
	assign take = sv_s1 && elig && (!best_found_q || ($signed(sd_s1) > best_score_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q   <= sidx_s1;
			best_score_q <= $signed(sd_s1);
		end
	end

	// Candidate box.
	logic [BOX_W-1:0]  cbox_q;
	logic [EXTS_W-1:0] cext_q;

	always_ff @(posedge clk) begin
		cbox_q <= box_mem[best_idx_q];
		if (cmd.ext_ld) begin
			cext_q <= box_ext(cbox_q, fmt_q);
		end
		if (cmd.keep) begin
			kext_mem[kept_cnt_q[IDX_W-1:0]] <= cext_q;
			kidx_mem[kept_cnt_q[IDX_W-1:0]] <= best_idx_q;
		end
	end

	// Overlap pipeline: kept box against candidate.
	logic [EXTS_W-1:0]        ke_s1;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DIF_W-1:0]  iw_s2, ih_s2, dxk_s2, dyk_s2, dxc_s2, dyc_s2;
	logic signed [AREA_W-1:0] inter_s3, ak_s3, ac_s3;
	logic                     ipos_s3;
	logic [AREA_W-1:0]        inter_s4;
	logic [SUM_W-1:0]         uni_s4;
	logic                     ok_s4;
	logic [PROD_W-1:0]        lhs_s5, rhs_s5;
	logic                     ok_s5;
	logic                     supp_q;

	logic signed [EXT_W-1:0] k0, k1, k2, k3, c0, c1, c2, c3;
	logic signed [EXT_W-1:0] xmn, xmx, ymn, ymx;
	logic [SUM_W-1:0]        sum;

	assign {k3, k2, k1, k0} = ke_s1;
	assign {c3, c2, c1, c0} = cext_q;
	assign xmn = (k1 < c1) ? k1 : c1;
	assign xmx = (k0 > c0) ? k0 : c0;
	assign ymn = (k3 < c3) ? k3 : c3;
	assign ymx = (k2 > c2) ? k2 : c2;
	assign sum = SUM_W'($unsigned(ak_s3)) + SUM_W'($unsigned(ac_s3));

	always_ff @(posedge clk) begin
		ke_s1    <= kext_mem[chk_cnt_q[IDX_W-1:0]];
		iw_s2    <= DIF_W'(xmn) - DIF_W'(xmx);
		ih_s2    <= DIF_W'(ymn) - DIF_W'(ymx);
		dxk_s2   <= DIF_W'(k1) - DIF_W'(k0);
		dyk_s2   <= DIF_W'(k3) - DIF_W'(k2);
		dxc_s2   <= DIF_W'(c1) - DIF_W'(c0);
		dyc_s2   <= DIF_W'(c3) - DIF_W'(c2);
		inter_s3 <= iw_s2 * ih_s2;
		ak_s3    <= dxk_s2 * dyk_s2;
		ac_s3    <= dxc_s2 * dyc_s2;
		ipos_s3  <= (iw_s2 > 0) && (ih_s2 > 0);
		inter_s4 <= $unsigned(inter_s3);
		uni_s4   <= sum - SUM_W'($unsigned(inter_s3));
		ok_s4    <= ipos_s3 && (ak_s3 > 0) && (ac_s3 > 0) &&
			(sum > SUM_W'($unsigned(inter_s3)));
		lhs_s5   <= PROD_W'(inter_s4) << THR_W;
		rhs_s5   <= PROD_W'(uni_s4) * PROD_W'(iou_thr_q);
		ok_s5    <= ok_s4;
	end

	// Output register.
	logic [IDX_W-1:0]   kidx_s1;
	logic               out_valid_q, out_vres_q, out_ovf_q, out_last_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [BATCH_W-1:0] out_batch_q;
	logic [CLASS_W-1:0] out_class_q;
	logic               kept_none, last_res;

	assign kept_none = (kept_cnt_q == '0);
	assign last_res  = kept_none || ((out_cnt_q + 1'b1) == kept_cnt_q);

	always_ff @(posedge clk) begin
		kidx_s1 <= kidx_mem[out_cnt_q[IDX_W-1:0]];
		if (cmd.out_ld) begin
			out_idx_q   <= kept_none ? '0 : kidx_s1;
			out_vres_q  <= !kept_none;
			out_ovf_q   <= ovf_q;
			out_last_q  <= last_res;
			out_batch_q <= batch_q;
			out_class_q <= class_q;
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q   <= '0;
			kept_cnt_q   <= '0;
			scan_cnt_q   <= '0;
			chk_cnt_q    <= '0;
			out_cnt_q    <= '0;
			ovf_q        <= 1'b0;
			visited_q    <= '0;
			sv_s1        <= 1'b0;
			best_found_q <= 1'b0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			v_s5         <= 1'b0;
			supp_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.ld) begin
				if (room) begin
					load_cnt_q <= load_cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
			sv_s1 <= cmd.scan_issue;
			if (cmd.scan_clr) begin
				scan_cnt_q   <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
				if (take) begin
					best_found_q <= 1'b1;
				end
			end
			if (cmd.pick) begin
				visited_q[best_idx_q] <= 1'b1;
			end
			v_s1 <= cmd.chk_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			if (cmd.chk_clr) begin
				chk_cnt_q <= '0;
				supp_q    <= 1'b0;
			end else begin
				if (cmd.chk_issue) begin
					chk_cnt_q <= chk_cnt_q + 1'b1;
				end
				if (v_s5 && ok_s5 && (lhs_s5 > rhs_s5)) begin
					supp_q <= 1'b1;
				end
			end
			if (cmd.keep) begin
				kept_cnt_q <= kept_cnt_q + 1'b1;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.out_next) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end
			if (cmd.set_clr) begin
				load_cnt_q <= '0;
				kept_cnt_q <= '0;
				out_cnt_q  <= '0;
				ovf_q      <= 1'b0;
				visited_q  <= '0;
			end
		end
	end

	always_comb begin
		sts.scan_rem  = (scan_cnt_q < load_cnt_q);
		sts.scan_pend = sv_s1;
		sts.found     = best_found_q;
		sts.chk_rem   = (chk_cnt_q < kept_cnt_q);
		sts.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
		sts.supp      = supp_q;
		sts.lim_next  = (max_sel_q != '0) &&
			((kept_cnt_q + 1'b1) == CNT_W'(max_sel_q));
		sts.out_taken = out_valid_q && out_ready;
		sts.out_last  = out_last_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = {out_idx_q, out_class_q, out_batch_q};
	assign out_user  = {out_ovf_q, out_vres_q};
	assign out_last  = out_last_q;

endmodule

[sv/nms_checker.sv]
// ---------------------------------------------------------------------------
// nms_checker: port-level checks for the suppression block
// Watches the top-level ports and flags results that break the set rules.
// ---------------------------------------------------------------------------
module nms_checker import nms_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser,
	input logic                  m_axis_tlast
);

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
		$stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Boxes are never taken while a result is on offer.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("box taken during result delivery");

	// The final result of a set frees the input side.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("input not ready after final result");

	// An empty set gives a single closing result with index zero.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |->
		m_axis_tlast && (m_axis_tdata[OUT_DATA_W-1 -: IDX_W] == '0))
		else $error("malformed empty-set result");

endmodule

bind non_max_suppression_top nms_checker u_nms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
